// ===== rtl/rtcmubx_pkg.sv =====
// ---------------------------------------------------------------------------
// rtcmubx_pkg
// Shared types, codes and the byte-wide CRC-24Q step for the frame parser.
// ---------------------------------------------------------------------------
package rtcmubx_pkg;

    // framing bytes
    localparam logic [7:0] RTCM_PREAMBLE = 8'hD3;
    localparam logic [7:0] UBX_SYNC1     = 8'hB5;
    localparam logic [7:0] UBX_SYNC2     = 8'h62;
    localparam logic [7:0] RTCM_LEN_MASK = 8'h03;

    // crc-24q, msb first, zero init
    localparam logic [24:0] CRC24Q_POLY = 25'h1864CFB;
    localparam logic [23:0] CRC24_MASK  = 24'hFFFFFF;

    // header, length and crc bytes around the rtcm payload
    localparam int RTCM_OVERHEAD = 6;

    // parameter defaults
    localparam int RTCM_MAX_FRAME_DEF  = 1029;
    localparam int UBX_MAX_PAYLOAD_DEF = 1024;

    typedef enum logic [1:0] {
        EV_NONE      = 2'd0,
        EV_RTCM_GOOD = 2'd1,
        EV_RTCM_BAD  = 2'd2,
        EV_UBX_GOOD  = 2'd3
    } t_event;

    typedef enum logic [7:0] {
        PH_SEARCH = 8'b0000_0001,
        PH_RHDR   = 8'b0000_0010,
        PH_RBODY  = 8'b0000_0100,
        PH_USYNC  = 8'b0000_1000,
        PH_UHDR   = 8'b0001_0000,
        PH_UPAY   = 8'b0010_0000,
        PH_UCKA   = 8'b0100_0000,
        PH_UCKB   = 8'b1000_0000
    } t_phase;

    typedef struct packed {
        t_event      event_res;
        logic [11:0] rtcm_type;
        logic [10:0] rtcm_length;
        logic [7:0]  ubx_class;
        logic [7:0]  ubx_id;
        logic [10:0] ubx_length;
        logic [31:0] good_frames;
        logic [31:0] bad_frames;
    } t_result;

    // one byte through the crc, eight shift steps
    function automatic logic [23:0] crc24q_byte(input logic [23:0] crc, input logic [7:0] b);
        logic [24:0] c;
        c = {1'b0, crc ^ {b, 16'h0000}};
        for (int k = 0; k < 8; k++) begin
            c = {c[23:0], 1'b0};
            if (c[24]) begin
                c = c ^ CRC24Q_POLY;
            end
        end
        return c[23:0] & CRC24_MASK;
    endfunction

endpackage

// ===== rtl/rtcm_ubx_frame_parser.sv =====
// ---------------------------------------------------------------------------
// rtcm_ubx_frame_parser
// Byte-stream hunter for RTCM3 (CRC-24Q) and UBX (Fletcher-8) frames.
// ---------------------------------------------------------------------------
// One receiver byte goes in per transaction and exactly one result comes out
// for it, in order. The block sustains one byte per clock while results are
// taken: a byte is held in the input register, the CRC-24Q and Fletcher
// updates plus the frame state machine run on it there, and the result lands
// in the output register. Back-pressure on the result side stalls both
// registers; the input side keeps accepting while either register has room.
// A result reports an event (tuser) only on the last byte of a frame: valid
// RTCM with its message number and total length, RTCM with a bad CRC, or
// valid UBX with class, id and payload length; all other data fields are
// zero then, except the two wrapping RTCM good/bad frame counters, which
// always show their value after this byte. A zero or oversized RTCM length,
// an oversized UBX length or a broken UBX sync restarts the hunt at the next
// byte. A UBX frame with a bad checksum is dropped silently.
// ---------------------------------------------------------------------------
module rtcm_ubx_frame_parser #(
    parameter int RTCM_MAX_FRAME  = rtcmubx_pkg::RTCM_MAX_FRAME_DEF,
    parameter int UBX_MAX_PAYLOAD = rtcmubx_pkg::UBX_MAX_PAYLOAD_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // input byte stream
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [7:0]   i_s_axis_tdata,   // [7:0] data_byte
    // result stream
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // [11:0] rtcm_type, [22:12] rtcm_length, [30:23] ubx_class, [38:31] ubx_id,
    // [49:39] ubx_length, [81:50] good_frames, [113:82] bad_frames, rest zero
    output logic [119:0] o_m_axis_tdata,
    output logic [1:0]   o_m_axis_tuser    // [1:0] event_res
);

    // length limits at the widths they are compared at
    localparam logic [11:0] RtcmMax = 12'(RTCM_MAX_FRAME);
    localparam logic [16:0] UbxMax  = 17'(UBX_MAX_PAYLOAD);

    // pipeline control
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    logic       w_adv;    // output register can take a new result
    logic       w_proc;   // the held byte is processed this cycle

    // frame state
    rtcmubx_pkg::t_phase r_phase, n_phase;
    logic [10:0] r_count, n_count;
    logic [10:0] r_expected, n_expected;
    logic [23:0] r_crc, n_crc;
    logic [15:0] r_type_bytes, n_type_bytes;
    logic [7:0]  r_ubx_class, n_ubx_class;
    logic [7:0]  r_ubx_id, n_ubx_id;
    logic [15:0] r_ubx_len, n_ubx_len;
    logic [15:0] r_ubx_index, n_ubx_index;
    logic [7:0]  r_sum_a, n_sum_a;
    logic [7:0]  r_sum_b, n_sum_b;
    logic [7:0]  r_rx_sum_a, n_rx_sum_a;
    logic [31:0] r_good_count, n_good_count;
    logic [31:0] r_bad_count, n_bad_count;

    rtcmubx_pkg::t_result r_result, n_result;

    // shared pieces of the next-state logic
    logic [23:0] w_crc_step;
    logic [10:0] w_count_inc;
    logic [9:0]  w_pl;
    logic [11:0] w_pl_total;
    logic [7:0]  w_fl_a;
    logic [7:0]  w_fl_b;
    logic [15:0] w_index_inc;

    assign w_adv           = !r_out_valid || i_m_axis_tready;
    assign w_proc          = r_in_valid && w_adv;
    assign o_s_axis_tready = !r_in_valid || w_adv;

    assign w_crc_step  = rtcmubx_pkg::crc24q_byte(r_crc, r_in_byte);
    assign w_count_inc = r_count + 11'd1;
    assign w_pl        = {r_expected[9:8], r_in_byte};
    assign w_pl_total  = 12'(w_pl) + 12'(rtcmubx_pkg::RTCM_OVERHEAD);
    assign w_fl_a      = r_sum_a + r_in_byte;
    assign w_fl_b      = r_sum_b + w_fl_a;
    assign w_index_inc = r_ubx_index + 16'd1;

    // ---------------------------------------------------------------------
    // frame state machine, one byte per pass
    // ---------------------------------------------------------------------
    always_comb begin
        logic hunt;    // restart the preamble search

        hunt         = 1'b0;
        n_phase      = r_phase;
        n_count      = r_count;
        n_expected   = r_expected;
        n_crc        = r_crc;
        n_type_bytes = r_type_bytes;
        n_ubx_class  = r_ubx_class;
        n_ubx_id     = r_ubx_id;
        n_ubx_len    = r_ubx_len;
        n_ubx_index  = r_ubx_index;
        n_sum_a      = r_sum_a;
        n_sum_b      = r_sum_b;
        n_rx_sum_a   = r_rx_sum_a;
        n_good_count = r_good_count;
        n_bad_count  = r_bad_count;

        n_result             = '0;
        n_result.event_res   = rtcmubx_pkg::EV_NONE;

        unique case (r_phase)
            rtcmubx_pkg::PH_SEARCH: begin
                if (r_in_byte == rtcmubx_pkg::RTCM_PREAMBLE) begin
                    n_crc   = rtcmubx_pkg::crc24q_byte(24'h000000, r_in_byte);
                    n_count = 11'd1;
                    n_phase = rtcmubx_pkg::PH_RHDR;
                end else if (r_in_byte == rtcmubx_pkg::UBX_SYNC1) begin
                    n_phase = rtcmubx_pkg::PH_USYNC;
                end
            end
            rtcmubx_pkg::PH_RHDR: begin
                n_crc   = w_crc_step;
                n_count = w_count_inc;
                if (w_count_inc == 11'd2) begin
                    // only the low two bits of this byte carry length
                    n_expected = {1'b0, r_in_byte[1:0] & rtcmubx_pkg::RTCM_LEN_MASK[1:0],
                                  8'h00};
                end else if (w_pl == 10'd0 || w_pl_total > RtcmMax) begin
                    hunt = 1'b1;
                end else begin
                    n_expected = w_pl_total[10:0];
                    n_phase    = rtcmubx_pkg::PH_RBODY;
                end
            end
            rtcmubx_pkg::PH_RBODY: begin
                n_crc   = w_crc_step;
                n_count = w_count_inc;
                if (w_count_inc == 11'd4) begin
                    n_type_bytes[15:8] = r_in_byte;
                end else if (w_count_inc == 11'd5) begin
                    n_type_bytes[7:0] = r_in_byte;
                end
                if (w_count_inc >= r_expected) begin
                    // crc over the whole frame including its crc leaves zero
                    if (w_crc_step == 24'h000000) begin
                        n_good_count         = r_good_count + 32'd1;
                        n_result.event_res   = rtcmubx_pkg::EV_RTCM_GOOD;
                        n_result.rtcm_type   = n_type_bytes[15:4];
                        n_result.rtcm_length = w_count_inc;
                    end else begin
                        n_bad_count        = r_bad_count + 32'd1;
                        n_result.event_res = rtcmubx_pkg::EV_RTCM_BAD;
                    end
                    hunt = 1'b1;
                end
            end
            rtcmubx_pkg::PH_USYNC: begin
                if (r_in_byte == rtcmubx_pkg::UBX_SYNC2) begin
                    n_sum_a     = 8'h00;
                    n_sum_b     = 8'h00;
                    n_ubx_index = 16'h0000;
                    n_phase     = rtcmubx_pkg::PH_UHDR;
                end else begin
                    hunt = 1'b1;
                end
            end
            rtcmubx_pkg::PH_UHDR: begin
                // class, id, length low, length high
                case (r_ubx_index)
                    16'd0:   n_ubx_class = r_in_byte;
                    16'd1:   n_ubx_id    = r_in_byte;
                    16'd2:   n_ubx_len   = {8'h00, r_in_byte};
                    default: n_ubx_len   = {r_in_byte, r_ubx_len[7:0]};
                endcase
                n_sum_a     = w_fl_a;
                n_sum_b     = w_fl_b;
                n_ubx_index = w_index_inc;
                if (w_index_inc >= 16'd4) begin
                    n_ubx_index = 16'h0000;
                    if (17'(n_ubx_len) > UbxMax) begin
                        hunt = 1'b1;
                    end else if (n_ubx_len != 16'h0000) begin
                        n_phase = rtcmubx_pkg::PH_UPAY;
                    end else begin
                        n_phase = rtcmubx_pkg::PH_UCKA;
                    end
                end
            end
            rtcmubx_pkg::PH_UPAY: begin
                n_sum_a     = w_fl_a;
                n_sum_b     = w_fl_b;
                n_ubx_index = w_index_inc;
                if (w_index_inc == r_ubx_len) begin
                    n_phase = rtcmubx_pkg::PH_UCKA;
                end
            end
            rtcmubx_pkg::PH_UCKA: begin
                n_rx_sum_a = r_in_byte;
                n_phase    = rtcmubx_pkg::PH_UCKB;
            end
            rtcmubx_pkg::PH_UCKB: begin
                if (r_rx_sum_a == r_sum_a && r_in_byte == r_sum_b) begin
                    n_result.event_res  = rtcmubx_pkg::EV_UBX_GOOD;
                    n_result.ubx_class  = r_ubx_class;
                    n_result.ubx_id     = r_ubx_id;
                    n_result.ubx_length = r_ubx_len[10:0];
                end
                hunt = 1'b1;
            end
            default: begin
                hunt = 1'b1;
            end
        endcase

        if (hunt) begin
            n_phase     = rtcmubx_pkg::PH_SEARCH;
            n_count     = 11'd0;
            n_expected  = 11'd0;
            n_ubx_index = 16'h0000;
            n_ubx_len   = 16'h0000;
        end

        n_result.good_frames = n_good_count;
        n_result.bad_frames  = n_bad_count;
    end

    // ---------------------------------------------------------------------
    // registers
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_phase      <= rtcmubx_pkg::PH_SEARCH;
            r_count      <= '0;
            r_expected   <= '0;
            r_crc        <= '0;
            r_type_bytes <= '0;
            r_ubx_class  <= '0;
            r_ubx_id     <= '0;
            r_ubx_len    <= '0;
            r_ubx_index  <= '0;
            r_sum_a      <= '0;
            r_sum_b      <= '0;
            r_rx_sum_a   <= '0;
            r_good_count <= '0;
            r_bad_count  <= '0;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (w_adv) begin
                r_out_valid <= r_in_valid;
            end
            if (w_proc) begin
                r_phase      <= n_phase;
                r_count      <= n_count;
                r_expected   <= n_expected;
                r_crc        <= n_crc;
                r_type_bytes <= n_type_bytes;
                r_ubx_class  <= n_ubx_class;
                r_ubx_id     <= n_ubx_id;
                r_ubx_len    <= n_ubx_len;
                r_ubx_index  <= n_ubx_index;
                r_sum_a      <= n_sum_a;
                r_sum_b      <= n_sum_b;
                r_rx_sum_a   <= n_rx_sum_a;
                r_good_count <= n_good_count;
                r_bad_count  <= n_bad_count;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata;
        end
        if (w_proc) begin
            r_result <= n_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_result.event_res;
    assign o_m_axis_tdata  = {6'b000000,
                              r_result.bad_frames,
                              r_result.good_frames,
                              r_result.ubx_length,
                              r_result.ubx_id,
                              r_result.ubx_class,
                              r_result.rtcm_length,
                              r_result.rtcm_type};

    // ---------------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------------
`ifndef SYNTHESIS
    // a good rtcm frame is at least header, one payload byte and crc
    a_rtcm_len_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser == rtcmubx_pkg::EV_RTCM_GOOD)
            |-> (o_m_axis_tdata[22:12] >= 11'd7))
        else $error("good rtcm frame shorter than minimum");

    // good counter moves only with a good rtcm result
    a_good_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_good_count != $past(r_good_count))
            |-> $past(w_proc && n_result.event_res == rtcmubx_pkg::EV_RTCM_GOOD))
        else $error("good frame counter changed without a good frame");

    // the second ubx checksum byte always ends the frame
    a_ubx_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_proc && r_phase == rtcmubx_pkg::PH_UCKB) |=> (r_phase == rtcmubx_pkg::PH_SEARCH))
        else $error("hunt not restarted after ubx checksum");
`endif

endmodule
